// ===== design/dq_pkg.sv =====
package dq_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CountW   = 5;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [FuncW-1:0] {
    OP_PUT_BACK   = 3'd0,
    OP_PUT_FRONT  = 3'd1,
    OP_TAKE_BACK  = 3'd2,
    OP_TAKE_FRONT = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

endpackage

// ===== design/dq_ram.sv =====
module dq_ram #(
  parameter int unsigned Depth = dq_pkg::DefDepth,
  parameter int unsigned Width = dq_pkg::DataW,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== design/double_ended_queue_core.sv =====
// Double-ended queue of signed 32-bit elements held in a ring of DEPTH entries in one
// synchronous memory with one write and two read ports. Each input item carries an
// operation in s_axis_tuser (push back, push front, pop back, pop front, clear) and the
// element to push in s_axis_tdata; each one yields exactly one result item with the status
// (ok, pop on empty ignored, push on full ignored) in m_axis_tuser and the front and back
// elements, the count and an empty flag in m_axis_tdata. In S_IDLE the accept cycle
// updates the pointers and writes the memory, S_READ reads the front and back entries
// through the registered read ports, and S_LOAD moves the read data into the output
// register once that register is free or being taken. A finished result may wait in the
// output register while the next item is accepted and processed. Count is reported in
// its low five bits.
module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // value
  input  logic [dq_pkg::InDataW-1:0]    s_axis_tdata,
  // func
  input  logic [dq_pkg::FuncW-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // front_value, back_value, count, is_empty, zero pad
  output logic [dq_pkg::OutDataW-1:0]   m_axis_tdata,
  // status
  output logic [dq_pkg::StatW-1:0]      m_axis_tuser
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] fill_q, fill_d;
  stat_e stat_q, stat_d;

  logic                accept;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [DataW-1:0]    rd_front, rd_back;
  logic                out_load;
  logic                is_empty;
  logic [CW+4:0]       cnt_ext;

  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic [StatW-1:0]    m_user_q, m_user_d;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    fill_d  = fill_q;
    stat_d  = stat_q;
    we      = 1'b0;
    waddr   = back_q;
    if (accept) begin
      stat_d = STAT_OK;
      unique case (op_e'(s_axis_tuser))
        OP_PUT_BACK: begin
          if (fill_q == FullCnt) begin
            stat_d = STAT_FULL;
          end else begin
            we     = 1'b1;
            waddr  = back_q;
            back_d = idx_next(back_q);
            fill_d = fill_q + 1'b1;
          end
        end
        OP_PUT_FRONT: begin
          if (fill_q == FullCnt) begin
            stat_d = STAT_FULL;
          end else begin
            we      = 1'b1;
            waddr   = idx_prev(front_q);
            front_d = idx_prev(front_q);
            fill_d  = fill_q + 1'b1;
          end
        end
        OP_TAKE_BACK: begin
          if (fill_q == '0) begin
            stat_d = STAT_EMPTY;
          end else begin
            back_d = idx_prev(back_q);
            fill_d = fill_q - 1'b1;
          end
        end
        OP_TAKE_FRONT: begin
          if (fill_q == '0) begin
            stat_d = STAT_EMPTY;
          end else begin
            front_d = idx_next(front_q);
            fill_d  = fill_q - 1'b1;
          end
        end
        OP_CLEAR: begin
          front_d = '0;
          back_d  = '0;
          fill_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  dq_ram #(
    .Depth (DEPTH),
    .Width (DataW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (s_axis_tdata),
    .raddr_a_i (front_q),
    .raddr_b_i (idx_prev(back_q)),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_back)
  );

  assign out_load = (state_q == S_LOAD) && (!m_valid_q || m_axis_tready);
  assign is_empty = (fill_q == '0);
  assign cnt_ext  = {5'b0, fill_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_LOAD;
      S_LOAD: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (out_load) begin
      m_valid_d = 1'b1;
      m_user_d  = stat_q;
      m_data_d  = {2'b00, is_empty, cnt_ext[4:0],
                   is_empty ? '0 : rd_back,
                   is_empty ? '0 : rd_front};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      back_q    <= '0;
      fill_q    <= '0;
      stat_q    <= STAT_OK;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      back_q    <= back_d;
      fill_q    <= fill_d;
      stat_q    <= stat_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== design/dq_checker.sv =====
module dq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [dq_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [dq_pkg::FuncW-1:0]    s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [dq_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [dq_pkg::StatW-1:0]    m_axis_tuser
);
  import dq_pkg::*;

  logic in_acc;
  logic out_empty;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_empty = m_axis_tdata[69];

  // result waits unchanged until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("item accepted while busy");

  // an empty queue shows zero values and zero count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_empty |-> m_axis_tdata[68:0] == '0)
    else $error("empty result carries data");

  // a rejected pop means the queue was and stays empty
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> out_empty)
    else $error("pop rejected on a non-empty queue");

  // a rejected push means the queue is not empty
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STAT_FULL |-> !out_empty)
    else $error("push rejected on an empty queue");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);

// ===== tb/double_ended_queue_core_tb.sv =====
module double_ended_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  typedef struct packed {
    stat_e              status;
    logic [DataW-1:0]   front_val;
    logic [DataW-1:0]   back_val;
    logic [CountW-1:0]  fill;
    logic               empty;
  } dq_result_t;

  typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [FuncW-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [StatW-1:0]     m_axis_tuser;

  // deque model state
  logic [DataW-1:0] dq_mem [DefDepth];
  int unsigned      head_idx  = 0;
  int unsigned      tail_idx  = 0;
  int unsigned      occupancy = 0;

  dq_result_t pending_results[$];
  dq_result_t exp_res;

  int       error_count  = 0;
  int       items_sent   = 0;
  int       results_seen = 0;
  int       full_hits    = 0;
  int       empty_hits   = 0;
  int       wrap_clears  = 0;
  int       gap_max      = 4;
  int       burst_left   = 0;
  int       push_pct     = 50;
  int       hold_req     = 0;
  int       hold_left    = 0;
  int       run_left     = 0;
  logic     rx_level     = 1'b1;
  rx_mode_e rx_mode      = RX_PATTERN;

  always #5 clk_i = ~clk_i;

  double_ended_queue_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic dq_result_t predict_deque_op(logic [FuncW-1:0] func,
                                                  logic [DataW-1:0] value);
    dq_result_t r;
    r = '0;
    r.status = STAT_OK;
    case (func)
      OP_PUT_BACK: begin
        if (occupancy == DefDepth) begin
          r.status = STAT_FULL;
        end else begin
          dq_mem[tail_idx] = value;
          tail_idx = (tail_idx + 1) % DefDepth;
          occupancy++;
        end
      end
      OP_PUT_FRONT: begin
        if (occupancy == DefDepth) begin
          r.status = STAT_FULL;
        end else begin
          head_idx = (head_idx + DefDepth - 1) % DefDepth;
          dq_mem[head_idx] = value;
          occupancy++;
        end
      end
      OP_TAKE_BACK: begin
        if (occupancy == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          tail_idx = (tail_idx + DefDepth - 1) % DefDepth;
          occupancy--;
        end
      end
      OP_TAKE_FRONT: begin
        if (occupancy == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          head_idx = (head_idx + 1) % DefDepth;
          occupancy--;
        end
      end
      OP_CLEAR: begin
        if (head_idx != 0 || tail_idx != 0) wrap_clears++;
        head_idx  = 0;
        tail_idx  = 0;
        occupancy = 0;
      end
      default: ;
    endcase
    if (occupancy != 0) begin
      r.front_val = dq_mem[head_idx];
      r.back_val  = dq_mem[(tail_idx + DefDepth - 1) % DefDepth];
    end
    r.fill  = CountW'(occupancy);
    r.empty = (occupancy == 0);
    if (r.status == STAT_FULL) full_hits++;
    if (r.status == STAT_EMPTY) empty_hits++;
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FuncW-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_CLEAR;
    if (r < 4) return FuncW'($urandom_range(int'(OP_CLEAR) + 1, (1 << FuncW) - 1));
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? OP_PUT_FRONT : OP_PUT_BACK;
    end
    return $urandom_range(0, 1) ? OP_TAKE_FRONT : OP_TAKE_BACK;
  endfunction

  task automatic send_item(input logic [FuncW-1:0] func, input logic [DataW-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    pending_results.insert(pending_results.size(), predict_deque_op(func, value));
    items_sent++;
  endtask

  task automatic test_empty_queue();
    send_item(OP_TAKE_BACK, pick_value());
    send_item(OP_TAKE_FRONT, pick_value());
    send_item(OP_CLEAR, pick_value());
    for (int f = int'(OP_CLEAR) + 1; f < (1 << FuncW); f++) begin
      send_item(FuncW'(f), pick_value());
    end
  endtask

  task automatic test_push_pop_ends();
    send_item(OP_PUT_BACK, 32'h8000_0000);
    send_item(OP_PUT_FRONT, 32'h7fff_ffff);
    send_item(OP_PUT_BACK, '1);
    send_item(OP_PUT_FRONT, '0);
    send_item(OP_TAKE_BACK, pick_value());
    send_item(OP_TAKE_FRONT, pick_value());
    send_item(OP_TAKE_FRONT, pick_value());
    send_item(OP_TAKE_BACK, pick_value());
  endtask

  task automatic test_full_queue();
    repeat (DefDepth) send_item($urandom_range(0, 1) ? OP_PUT_FRONT : OP_PUT_BACK, $urandom());
    send_item(OP_PUT_BACK, pick_value());
    send_item(OP_PUT_FRONT, pick_value());
    send_item(FuncW'(int'(OP_CLEAR) + 1), pick_value());
    send_item(OP_CLEAR, pick_value());
    send_item(OP_TAKE_FRONT, pick_value());
  endtask

  task automatic test_random_walk(input int n);
    for (int i = 0; i < n; i++) begin
      // swing between filling and draining so both ends of the ring get hit
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      send_item(pick_op(), pick_value());
    end
  endtask

  task automatic test_backpressure();
    push_pct = 70;
    hold_req = 300;
    repeat (40) send_item(pick_op(), pick_value());
  endtask

  task automatic test_back_to_back(input int n);
    gap_max = 0;
    rx_mode = RX_ALWAYS;
    test_random_walk(n);
    rx_mode = RX_PATTERN;
    gap_max = 4;
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] exp_v,
                             input logic [DataW-1:0] got_v);
    if (exp_v !== got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    end
  endtask

  // receiver: long hold-off on request, otherwise always ready or its own run-length pattern
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_mode == RX_ALWAYS) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (run_left == 0) begin
        rx_level = !rx_level;
        run_left = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 6);
      end
      run_left--;
      m_axis_tready <= rx_level;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result item, expected none, actual tdata=%h tuser=%h",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_res = pending_results[0];
        pending_results.delete(0);
        check_field("status", DataW'(exp_res.status), DataW'(m_axis_tuser));
        check_field("front_value", exp_res.front_val, m_axis_tdata[31:0]);
        check_field("back_value", exp_res.back_val, m_axis_tdata[63:32]);
        check_field("count", DataW'(exp_res.fill), DataW'(m_axis_tdata[68:64]));
        check_field("is_empty", DataW'(exp_res.empty), DataW'(m_axis_tdata[69]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_push_pop_ends();
    test_full_queue();
    test_random_walk(500);
    test_backpressure();
    test_back_to_back(200);
    gap_max = 8;
    test_random_walk(560);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("ran %0d items, checked %0d results, %0d errors", items_sent, results_seen,
             error_count);
    $display("push on full %0d times, pop on empty %0d times, clear with moved ends %0d times",
             full_hits, empty_hits, wrap_clears);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
